// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro expects signals clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/arpc_pkg.sv -----
// Package for the ARP cache: sizes, codes and transaction structs.
// No dependencies; used by every module of the block.
package arpc_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int N_IFACES    = 4;
	localparam int N_REGS      = 4;
	localparam int REG_IDX_W   = $clog2(N_REGS);
	localparam int CFG_IDX_W   = REG_IDX_W + 1;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_LEARN  = 1'b1
	} arpc_cmd_t;

	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_BADIF = 2'd1,
		ST_MISS  = 2'd2
	} arpc_status_t;

	typedef struct packed {
		arpc_cmd_t   cmd;
		logic [7:0]  iface;
		logic [47:0] sender_mac;
		logic [31:0] ip_addr;
		logic [31:0] target_ip;
	} arpc_item_t;

	typedef struct packed {
		arpc_status_t status;
		logic [47:0]  mac_out;
		logic         reply_needed;
	} arpc_result_t;

	typedef struct packed {
		logic [7:0]  iface;
		logic [47:0] mac;
		logic [31:0] ip;
	} arpc_entry_t;

	// Search key broadcast to every cell.
	typedef struct packed {
		arpc_cmd_t   cmd;
		logic [7:0]  iface;
		logic [47:0] mac;
		logic [31:0] ip;
	} arpc_key_t;

	typedef struct packed {
		logic shift;
		logic ip_wr;
	} arpc_cell_ctrl_t;

endpackage

// ----- design/arpc_cell.sv -----
// One cache entry cell: holds an entry, compares it with the broadcast key
// and takes its upstream neighbor's entry on a shift. Depends on arpc_pkg.
module arpc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  arpc_pkg::arpc_key_t       key,
	input  arpc_pkg::arpc_cell_ctrl_t ctrl,
	input  arpc_pkg::arpc_entry_t     prev_entry,
	output arpc_pkg::arpc_entry_t     entry,
	output logic                      hit
);
	import arpc_pkg::*;

	arpc_entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.shift) begin
			entry_q <= prev_entry;
		end else if (ctrl.ip_wr) begin
			entry_q.ip <= key.ip;
		end
	end

	// Lookup matches on interface and IP, learn on interface and MAC.
	always_comb begin
		if (key.cmd == CMD_LEARN) begin
			hit = (entry_q.iface == key.iface) && (entry_q.mac == key.mac);
		end else begin
			hit = (entry_q.iface == key.iface) && (entry_q.ip == key.ip);
		end
	end

	assign entry = entry_q;

endmodule

// ----- design/arp_cache_fifo_learn_lookup_unit.sv -----
// Top level of the ARP neighbor cache with FIFO replacement.
// Depends on arpc_pkg and arpc_cell.
//
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. busy stays low, so one transaction can be taken per cycle.
//   Result channel: done pulses for one cycle, in the cycle after the command
//   edge, with status, mac_out and reply_needed on result. The receiver
//   cannot stall; done marks the result for that single cycle only.
//   Config port: cfg_we writes cfg_data to interface address cfg_idx at the
//   clock edge; indexes of N_REGS and up are dropped.
// The result path is the row of entry cells comparing the key in parallel,
//   then a first-match select over all cells.
// The table is a chain of TABLE_DEPTH cells; a learn that misses shifts
// every cell one place down and loads the new entry into cell 0, while a
// learn that hits rewrites the IP of the first matching cell.
// Reset: all cells and interface addresses clear to zero; a zeroed cell is
//   a real entry (interface 0, MAC 0, IP 0). No result is pending after reset.
module arp_cache_fifo_learn_lookup_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  arpc_pkg::arpc_item_t                  item,
	output logic                                  done,
	output arpc_pkg::arpc_result_t                result,
	input  logic                                  cfg_we,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [arpc_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import arpc_pkg::*;

	logic [CFG_DATA_W-1:0] iface_ip_q [N_REGS];
	logic                  done_q;
	arpc_result_t          result_q;

	logic                  accept;
	logic [7:0]            learn_if;
	arpc_key_t             key;
	arpc_entry_t           new_entry;
	arpc_entry_t           ent   [TABLE_DEPTH];
	arpc_entry_t           chain [TABLE_DEPTH];
	arpc_cell_ctrl_t       ctrl  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [TABLE_DEPTH-1:0] first_oh;
	logic                  any_hit;
	logic [47:0]           hit_mac;
	logic                  reply;
	arpc_result_t          result_d;

	// busy is never raised; every transaction is taken when start is high.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign learn_if = item.iface - 8'd1;

	always_comb begin
		key.cmd   = item.cmd;
		key.iface = (item.cmd == CMD_LEARN) ? learn_if : item.iface;
		key.mac   = item.sender_mac;
		key.ip    = item.ip_addr;
		new_entry.iface = learn_if;
		new_entry.mac   = item.sender_mac;
		new_entry.ip    = item.ip_addr;
	end

	// Isolate the lowest set hit bit.
	assign first_oh = hit_vec & (~hit_vec + TABLE_DEPTH'(1));
	assign any_hit  = |hit_vec;

	always_comb begin
		hit_mac = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_mac = hit_mac | (ent[i].mac & {48{first_oh[i]}});
		end
	end

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			ctrl[i].shift = accept && (item.cmd == CMD_LEARN) && !any_hit;
			ctrl[i].ip_wr = accept && (item.cmd == CMD_LEARN) && first_oh[i];
			chain[i]      = (i == 0) ? new_entry : ent[(i == 0) ? 0 : i - 1];
		end
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		arpc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.key        (key),
			.ctrl       (ctrl[g]),
			.prev_entry (chain[g]),
			.entry      (ent[g]),
			.hit        (hit_vec[g])
		);
	end

	assign reply = (learn_if < 8'(N_IFACES)) &&
		(item.target_ip == iface_ip_q[learn_if[REG_IDX_W-1:0]]);

	always_comb begin
		result_d.status       = ST_HIT;
		result_d.mac_out      = '0;
		result_d.reply_needed = 1'b0;
		if (item.cmd == CMD_LEARN) begin
			result_d.reply_needed = reply;
		end else if (item.iface >= 8'(N_IFACES)) begin
			result_d.status = ST_BADIF;
		end else if (any_hit) begin
			result_d.mac_out = hit_mac;
		end else begin
			result_d.status = ST_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_REGS; i++) begin
				iface_ip_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(N_REGS))) begin
			iface_ip_q[cfg_idx[REG_IDX_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- design/arpc_checker.sv -----
// Port-level checker for the ARP cache top level, attached by bind.
// Depends on arpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arpc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input arpc_pkg::arpc_item_t            item,
	input logic                            done,
	input arpc_pkg::arpc_result_t          result,
	input logic                            cfg_we,
	input logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import arpc_pkg::*;

	`ASSERT_NEXT(a_done_after_cmd, start && !busy, done, "no result after accepted command")
	`ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done, "result without a command")
	`ASSERT_IMPL(a_mac_zero_on_nonhit, done && (result.status != ST_HIT), result.mac_out == '0, "nonzero MAC on non-hit")
	`ASSERT_NEXT(a_badif_lookup, start && !busy && (item.cmd == CMD_LOOKUP) && (item.iface >= 8'(N_IFACES)), result.status == ST_BADIF, "bad interface not flagged")
	`ASSERT_NEXT(a_no_reply_on_lookup, start && !busy && (item.cmd == CMD_LOOKUP), !result.reply_needed, "reply flag on lookup")

endmodule

bind arp_cache_fifo_learn_lookup_unit arpc_checker u_arpc_checker (.*);

// ----- sim/arpc_checker.sv -----
`timescale 1ns / 1ps
// Checker for the ARP cache: watches the command, result and config channels,
// predicts each result from its own copy of the neighbor table, and compares.
// Depends on arpc_pkg.
module arpc_scoreboard
	import arpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  arpc_item_t            item,
	input  logic                  done,
	input  arpc_result_t          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           pending,
	output int unsigned           mismatches,
	output int unsigned           n_results,
	output int unsigned           n_lookup_hits,
	output int unsigned           n_learns,
	output int unsigned           n_replies
);

	arpc_entry_t  neighbor_tbl [TABLE_DEPTH];
	logic [31:0]  iface_addr [N_REGS];
	arpc_result_t answers_due [$];
	arpc_result_t due;
	arpc_result_t want;

	// Resolve one transaction against the table and update it for a learn.
	function automatic arpc_result_t arp_answer(arpc_item_t it);
		arpc_result_t r;
		logic [7:0]   ifc;
		bit           found;
		r.status       = ST_HIT;
		r.mac_out      = '0;
		r.reply_needed = 1'b0;
		found          = 0;
		if (it.cmd == CMD_LOOKUP) begin
			if (it.iface >= N_IFACES) begin
				r.status = ST_BADIF;
			end else begin
				r.status = ST_MISS;
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (!found && neighbor_tbl[i].iface == it.iface &&
							neighbor_tbl[i].ip == it.ip_addr) begin
						found     = 1;
						r.status  = ST_HIT;
						r.mac_out = neighbor_tbl[i].mac;
					end
				end
				if (found)
					n_lookup_hits++;
			end
		end else begin
			n_learns++;
			// port tag counts from one; a tag of zero wraps to 255
			ifc = it.iface - 8'd1;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (!found && neighbor_tbl[i].iface == ifc &&
						neighbor_tbl[i].mac == it.sender_mac) begin
					found              = 1;
					neighbor_tbl[i].ip = it.ip_addr;
				end
			end
			if (!found) begin
				for (int i = TABLE_DEPTH - 1; i > 0; i--)
					neighbor_tbl[i] = neighbor_tbl[i - 1];
				neighbor_tbl[0].iface = ifc;
				neighbor_tbl[0].mac   = it.sender_mac;
				neighbor_tbl[0].ip    = it.ip_addr;
			end
			if (ifc < N_IFACES && it.target_ip == iface_addr[ifc[REG_IDX_W-1:0]]) begin
				r.reply_needed = 1'b1;
				n_replies++;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				neighbor_tbl[i] = '0;
			for (int i = 0; i < N_REGS; i++)
				iface_addr[i] = '0;
			answers_due.delete();
			pending <= 0;
		end else begin
			if (done === 1'b1) begin
				n_results++;
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no transaction outstanding: %s",
							$realtime,
							$sformatf("status=%0d mac=%h reply=%0b",
								result.status, result.mac_out,
								result.reply_needed));
				end else begin
					due = answers_due.pop_front();
					if (result.status !== due.status ||
							result.mac_out !== due.mac_out ||
							result.reply_needed !== due.reply_needed) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: exp %s, got %s",
								$realtime,
								$sformatf("status=%0d mac=%h reply=%0b",
									due.status, due.mac_out,
									due.reply_needed),
								$sformatf("status=%0d mac=%h reply=%0b",
									result.status, result.mac_out,
									result.reply_needed));
					end
				end
			end
			// indexes past the last register are dropped
			if (cfg_we === 1'b1 && cfg_idx < N_REGS)
				iface_addr[cfg_idx[REG_IDX_W-1:0]] = cfg_data;
			if (start === 1'b1 && busy === 1'b0) begin
				want = arp_answer(item);
				answers_due.push_back(want);
			end
			pending <= answers_due.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the ARP cache testbench: clock, reset, command and config stimulus.
// Depends on arpc_pkg, arp_cache_fifo_learn_lookup_unit and arpc_scoreboard.
module tb_top;
	import arpc_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RAND_PER_SET = 225;
	localparam int N_SETTINGS  = 6;
	localparam int POOL_SZ     = 12;
	localparam int POOL_IDX_W  = $clog2(POOL_SZ);

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	arpc_item_t            item;
	logic                  done;
	arpc_result_t          result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned pending, mismatches, n_results, n_lookup_hits, n_learns, n_replies;
	int unsigned cycles;
	bit          steady;
	logic [47:0] mac_pool [POOL_SZ];
	logic [31:0] ip_pool [POOL_SZ];
	logic [31:0] addr_now [N_REGS];

	arp_cache_fifo_learn_lookup_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	arpc_scoreboard i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.done          (done),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.pending       (pending),
		.mismatches    (mismatches),
		.n_results     (n_results),
		.n_lookup_hits (n_lookup_hits),
		.n_learns      (n_learns),
		.n_replies     (n_replies)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [47:0] rand_mac();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[47:0];
	endfunction

	function automatic logic [POOL_IDX_W-1:0] pool_idx();
		return POOL_IDX_W'($urandom_range(0, POOL_SZ - 1));
	endfunction

	// Mostly short gaps, a few long ones; steady stretches send back to back.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if ($urandom_range(0, 29) == 0)
			steady = !steady;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Learns and lookups drawn mostly from small pools so entries hit and get evicted.
	function automatic arpc_item_t next_arp_item();
		arpc_item_t  it;
		int unsigned r;
		it.sender_mac = rand_mac();
		it.ip_addr    = $urandom();
		it.target_ip  = $urandom();
		if ($urandom_range(0, 99) < 45) begin
			it.cmd = CMD_LEARN;
			r = $urandom_range(0, 9);
			if (r < 8)
				it.iface = 8'($urandom_range(1, N_IFACES));
			else if (r == 8)
				it.iface = 8'd0;
			else
				it.iface = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) < 7)
				it.sender_mac = mac_pool[pool_idx()];
			if ($urandom_range(0, 9) < 7)
				it.ip_addr = ip_pool[pool_idx()];
			r = $urandom_range(0, 9);
			if (r < 4 && it.iface >= 1 && it.iface <= N_IFACES)
				it.target_ip = addr_now[REG_IDX_W'(it.iface - 8'd1)];
			else if (r < 7)
				it.target_ip = ip_pool[pool_idx()];
		end else begin
			it.cmd = CMD_LOOKUP;
			if ($urandom_range(0, 99) < 85)
				it.iface = 8'($urandom_range(0, N_IFACES - 1));
			else
				it.iface = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < 75)
				it.ip_addr = ip_pool[pool_idx()];
		end
		return it;
	endfunction

	task automatic issue_arp(arpc_item_t it);
		int unsigned gap;
		gap = pick_gap();
		item  <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic directed_arp(arpc_cmd_t cmd, logic [7:0] tag, logic [47:0] mac,
			logic [31:0] ip, logic [31:0] tgt);
		arpc_item_t it;
		it.cmd        = cmd;
		it.iface      = tag;
		it.sender_mac = mac;
		it.ip_addr    = ip;
		it.target_ip  = tgt;
		issue_arp(it);
	endtask

	// Hold off until every transaction taken so far has produced its result.
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_iface_addr(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx < N_REGS)
			addr_now[idx[REG_IDX_W-1:0]] = val;
	endtask

	initial begin
		logic [31:0] v;
		cycles   = 0;
		steady   = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		item     = '0;
		cfg_we   = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		for (int i = 0; i < N_REGS; i++)
			addr_now[i] = '0;
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		ip_pool[0]  = '0;
		ip_pool[1]  = '1;
		for (int i = 2; i < POOL_SZ; i++) begin
			mac_pool[i] = rand_mac();
			ip_pool[i]  = $urandom();
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with all interface addresses at their reset value of zero.
		directed_arp(CMD_LOOKUP, 8'd0,   48'h0,            32'h0,        32'h0);
		directed_arp(CMD_LOOKUP, 8'd1,   48'h0,            32'h0,        32'h0);
		directed_arp(CMD_LOOKUP, 8'd4,   48'h0,            32'h0,        32'h0);
		directed_arp(CMD_LOOKUP, 8'd255, 48'hffff_ffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		directed_arp(CMD_LEARN,  8'd0,   48'h0123_4567_89ab, 32'h0a00_0001, 32'h0);
		directed_arp(CMD_LEARN,  8'd1,   48'h0,            32'hc0a8_0001, 32'h0);
		directed_arp(CMD_LOOKUP, 8'd0,   48'h0,            32'hc0a8_0001, 32'h0);
		directed_arp(CMD_LOOKUP, 8'd0,   48'h0,            32'h0,        32'h0);
		directed_arp(CMD_LEARN,  8'd4,   48'hffff_ffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		directed_arp(CMD_LOOKUP, 8'd3,   48'h0,            32'hffff_ffff, 32'h0);
		directed_arp(CMD_LEARN,  8'd4,   48'hffff_ffff_ffff, 32'h0a0a_0a0a, 32'h0);
		directed_arp(CMD_LOOKUP, 8'd3,   48'h0,            32'hffff_ffff, 32'h0);
		directed_arp(CMD_LOOKUP, 8'd3,   48'h0,            32'h0a0a_0a0a, 32'h0);
		directed_arp(CMD_LEARN,  8'd5,   48'haaaa_5555_aaaa, 32'h55aa_55aa, 32'h0);
		directed_arp(CMD_LOOKUP, 8'd4,   48'h0,            32'h55aa_55aa, 32'h0);
		directed_arp(CMD_LEARN,  8'd2,   48'h5555_aaaa_5555, 32'h8000_0000, 32'h0);
		directed_arp(CMD_LOOKUP, 8'd1,   48'h0,            32'h8000_0000, 32'h0);
		directed_arp(CMD_LEARN,  8'd255, 48'h1,            32'h1,        32'h0);
		directed_arp(CMD_LOOKUP, 8'd2,   48'h0,            32'h0,        32'h0);
		directed_arp(CMD_LEARN,  8'd3,   48'h8000_0000_0000, 32'h0,        32'h1);
		directed_arp(CMD_LOOKUP, 8'd2,   48'h0,            32'h0,        32'h0);

		for (int s = 0; s < N_SETTINGS; s++) begin
			if (s > 0) begin
				wait_drained();
				v = $urandom();
				for (int r = 0; r < N_REGS; r++) begin
					case (s)
						1: set_iface_addr(CFG_IDX_W'(r), 32'hffff_ffff);
						3: set_iface_addr(CFG_IDX_W'(r), v);
						4: set_iface_addr(CFG_IDX_W'(r),
							(r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : $urandom());
						default: set_iface_addr(CFG_IDX_W'(r), $urandom());
					endcase
				end
				// this write lands on an unused index and must change nothing
				set_iface_addr(CFG_IDX_W'($urandom_range(N_REGS, 2 ** CFG_IDX_W - 1)),
					$urandom());
				cfg_we <= 1'b0;
			end
			for (int k = 0; k < RAND_PER_SET; k++)
				issue_arp(next_arp_item());
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("checked %0d results: %0d learns, %0d lookup hits, %0d reply flags raised",
			n_results, n_learns, n_lookup_hits, n_replies);
		$display("over %0d interface address settings in %0d cycles", N_SETTINGS, cycles);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
